/* src/raycast_wall_column_texturer_top_defines.svh */
// Assertion macros shared by the checker.
`ifndef RAYCAST_WALL_COLUMN_TEXTURER_TOP_DEFINES_SVH
`define RAYCAST_WALL_COLUMN_TEXTURER_TOP_DEFINES_SVH
`define RCT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RCT_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

/* src/rct_pkg.sv */
package rct_pkg;
	localparam int TEX_SIZE = 64;
	localparam int TEX_BITS = 6;
	localparam int SCREEN_W = 1024;
	localparam int SCREEN_H = 768;
	localparam int NUM_TEXTURES = 6;
	localparam int MEM_DEPTH = NUM_TEXTURES * TEX_SIZE * TEX_SIZE;
	localparam int ADDR_W = 15;

	localparam logic [1:0] OP_SETUP = 2'd0;
	localparam logic [1:0] OP_PIXEL = 2'd1;
	localparam logic [1:0] OP_LOAD = 2'd2;

	localparam logic [2:0] NO_TEX = 3'd7;
	localparam logic [2:0] DOOR_SOLID_TEX = 3'd4;
	localparam logic [2:0] DOOR_SEE_TEX = 3'd5;
	localparam logic [31:0] DOOR_CLEAR = 32'hFF000000;
	localparam logic [31:0] WHITE = 32'h00FFFFFF;
	localparam logic [31:0] BLACK = 32'h00000000;

	typedef struct packed {
		logic [1:0] opcode;
		logic hit_side;
		logic signed [15:0] ray_dir_v;
		logic signed [15:0] ray_dir_h;
		logic [21:0] pos_v;
		logic [21:0] pos_h;
		logic [21:0] perp_dist;
		logic [15:0] line_height;
		logic [9:0] row;
		logic [9:0] column;
		logic [2:0] surface;
		logic [31:0] texel_value;
	} in_item_t;

	typedef struct packed {
		logic [9:0] screen_x;
		logic [9:0] screen_y;
		logic [31:0] color;
	} out_item_t;

	typedef struct packed {
		logic setup_start;
		logic pixel_start;
		logic load_start;
		logic pixel_finish;
	} cmd_t;

	typedef struct packed {
		logic setup_done;
		logic pixel_have;
	} status_t;
endpackage

/* src/raycast_wall_column_texturer_top.sv */
// Wall column texturer.
// Input channel in_valid/in_stall carries in_item: opcode 2 loads one texel
// into the six 64x64 texture memory, opcode 0 sets up a wall column, opcode 1
// draws the next pixel of that column. Opcode 3 is ignored.
// Output channel out_valid/out_stall carries out_item, one transfer per drawn
// pixel that has a texture or lies at the screen centre.
// A pixel result is offered in the ST_OUT state, after the ST_PIXEL state,
// as the texture memory read is registered. The next item is accepted in the
// cycle after the result transfer, or after the ST_PIXEL state for a pixel
// that gives no result.
// A setup holds the input while the 24-step bit-serial row step divider
// runs, with one multiply stage either side of it.
// One item is handled at a time; in_stall is high while an item is in work
// or a result is held. While the receiver stalls the result holds steady.
// Reset clears the column state and selects no texture; texture memory
// content is undefined until loaded.
module raycast_wall_column_texturer_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input rct_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output rct_pkg::out_item_t out_item
);
	import rct_pkg::*;

	cmd_t cmd;
	status_t status;

	rct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .opcode(in_item.opcode),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .cmd(cmd)
	);

	rct_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .item(in_item), .cmd(cmd),
		.status(status), .result(out_item)
	);
endmodule

/* src/rct_datapath.sv */
module rct_datapath (
	input logic clk,
	input logic arst_n,
	input rct_pkg::in_item_t item,
	input rct_pkg::cmd_t cmd,
	output rct_pkg::status_t status,
	output rct_pkg::out_item_t result
);
	import rct_pkg::*;

	logic [31:0] mem_q [MEM_DEPTH];
	logic [31:0] rdata_q;
	logic [9:0] column_x_q;
	logic [TEX_BITS-1:0] tex_column_q;
	logic [23:0] row_step_q;
	logic [31:0] row_accum_q;
	logic [2:0] tex_sel_q;
	in_item_t it_q;
	logic [9:0] y_q;
	logic centre_q;

	logic [37:0] prod_q;
	logic [2:0] phase_q;
	logic [23:0] quo_q;
	logic [22:0] rem_q;
	logic [4:0] div_cnt_q;
	logic div_busy_q;
	logic signed [17:0] base_q;

	logic [15:0] lh;
	logic signed [37:0] sprod;
	logic signed [15:0] ray_sel;
	logic [21:0] pos_sel;
	logic [15:0] frac;
	logic [TEX_BITS-1:0] col;
	logic [23:0] rem_try;
	logic [31:0] new_accum;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic signed [42:0] base_prod;
	logic [2:0] sel;

	assign lh = (it_q.line_height == 16'd0) ? 16'd1 : it_q.line_height;
	assign ray_sel = it_q.hit_side ? it_q.ray_dir_h : it_q.ray_dir_v;
	assign pos_sel = it_q.hit_side ? it_q.pos_h : it_q.pos_v;
	assign sprod = $signed({1'b0, it_q.perp_dist}) * ray_sel;
	assign frac = pos_sel[15:0] + prod_q[29:14];
	assign col = it_q.hit_side
		? (it_q.ray_dir_v > 0 ? ~frac[15:16-TEX_BITS] : frac[15:16-TEX_BITS])
		: (it_q.ray_dir_h < 0 ? ~frac[15:16-TEX_BITS] : frac[15:16-TEX_BITS]);
	assign rem_try = {rem_q, quo_q[23]} - {8'd0, lh};
	assign new_accum = row_accum_q + {8'd0, row_step_q};
	assign rd_addr = ADDR_W'({tex_sel_q, new_accum[16+TEX_BITS-1:16], tex_column_q});
	assign wr_addr = ADDR_W'({item.surface, item.row[TEX_BITS-1:0],
		item.column[TEX_BITS-1:0]});
	assign base_prod = base_q * $signed({1'b0, row_step_q});

	always_comb begin
		sel = NO_TEX;
		if (it_q.surface == 3'd1) begin
			sel = DOOR_SOLID_TEX;
		end else if (it_q.surface == 3'd2) begin
			sel = DOOR_SEE_TEX;
		end else if (!it_q.hit_side) begin
			sel = it_q.ray_dir_h > 0 ? 3'd2 : (it_q.ray_dir_h < 0 ? 3'd3 : NO_TEX);
		end else begin
			sel = it_q.ray_dir_v < 0 ? 3'd0 : (it_q.ray_dir_v > 0 ? 3'd1 : NO_TEX);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_start && item.surface < 3'(NUM_TEXTURES)
				&& item.row < 10'(TEX_SIZE) && item.column < 10'(TEX_SIZE)) begin
			mem_q[wr_addr] <= item.texel_value;
		end
		if (cmd.pixel_start) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup_start || cmd.pixel_start) begin
			it_q <= item;
		end
		if (cmd.pixel_start) begin
			y_q <= item.row;
		end
		prod_q <= sprod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_x_q <= '0;
			tex_column_q <= '0;
			row_step_q <= '0;
			row_accum_q <= '0;
			tex_sel_q <= NO_TEX;
			phase_q <= '0;
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			base_q <= '0;
			centre_q <= 1'b0;
		end else begin
			if (cmd.setup_start) begin
				phase_q <= 3'd1;
				column_x_q <= item.column;
			end else if (phase_q == 3'd1) begin
				phase_q <= 3'd2;
			end else if (phase_q == 3'd2) begin
				tex_column_q <= col;
				tex_sel_q <= sel;
				quo_q <= 24'(TEX_SIZE) << 16;
				rem_q <= '0;
				div_cnt_q <= 5'd24;
				div_busy_q <= 1'b1;
				base_q <= 18'(it_q.row) - 18'(SCREEN_H / 2) + 18'(lh[15:1]);
				phase_q <= 3'd3;
			end else if (phase_q == 3'd3) begin
				if (div_cnt_q != 0) begin
					if (!rem_try[23]) begin
						rem_q <= rem_try[22:0];
						quo_q <= {quo_q[22:0], 1'b1};
					end else begin
						rem_q <= {rem_q[21:0], quo_q[23]};
						quo_q <= {quo_q[22:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q - 5'd1;
				end else begin
					row_step_q <= quo_q;
					div_busy_q <= 1'b0;
					phase_q <= 3'd4;
				end
			end else if (phase_q == 3'd4) begin
				row_accum_q <= base_prod[31:0];
				phase_q <= 3'd0;
			end
			if (cmd.pixel_start) begin
				row_accum_q <= new_accum;
				centre_q <= column_x_q == 10'(SCREEN_W / 2) && item.row == 10'(SCREEN_H / 2);
			end
		end
	end

	always_comb begin
		result.screen_x = column_x_q;
		result.screen_y = y_q;
		if (centre_q) begin
			result.color = WHITE;
		end else if (tex_sel_q == DOOR_SEE_TEX && rdata_q == DOOR_CLEAR) begin
			result.color = BLACK;
		end else begin
			result.color = rdata_q;
		end
		status.pixel_have = centre_q || tex_sel_q < 3'(NUM_TEXTURES);
		status.setup_done = phase_q == 3'd0 && !div_busy_q;
	end
endmodule

/* src/rct_ctrl.sv */
module rct_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] opcode,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input rct_pkg::status_t status,
	output rct_pkg::cmd_t cmd
);
	import rct_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_PIXEL = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] wait_q;
	logic take;

	assign in_stall = state_q != ST_IDLE;
	assign take = in_valid && !in_stall;
	assign out_valid = state_q == ST_OUT;

	always_comb begin
		cmd.setup_start = take && opcode == OP_SETUP;
		cmd.pixel_start = take && opcode == OP_PIXEL;
		cmd.load_start = take && opcode == OP_LOAD;
		cmd.pixel_finish = out_valid && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.setup_start) begin
						state_q <= ST_SETUP;
						wait_q <= 2'd2;
					end else if (cmd.pixel_start) begin
						state_q <= ST_PIXEL;
					end
				end
				ST_SETUP: begin
					if (wait_q != 0) begin
						wait_q <= wait_q - 2'd1;
					end else if (status.setup_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PIXEL: begin
					state_q <= status.pixel_have ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (cmd.pixel_finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* src/rct_checker.sv */
module rct_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input rct_pkg::in_item_t in_item,
	input rct_pkg::out_item_t out_item
);
	import rct_pkg::*;
`include "raycast_wall_column_texturer_top_defines.svh"

	`RCT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
	`RCT_ASSERT_IMPL(a_one_item, clk, arst_n, out_valid |-> in_stall, "input taken while result pending")
	`RCT_ASSERT_NEXT(a_load_silent, clk, arst_n, in_valid && !in_stall && in_item.opcode == OP_LOAD, !out_valid, "load gave a result")
	`RCT_ASSERT_NEXT(a_busy_after, clk, arst_n, in_valid && !in_stall && in_item.opcode != OP_LOAD && in_item.opcode != 2'd3, in_stall, "item not held in work")
endmodule

bind raycast_wall_column_texturer_top rct_checker u_rct_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .in_item(in_item),
	.out_item(out_item)
);

/* sim/rct_checker.sv */
`timescale 1ns / 100ps
module rct_scoreboard (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input rct_pkg::in_item_t in_item,
	input logic out_valid,
	input logic out_stall,
	input rct_pkg::out_item_t out_item,
	output int fail_count,
	output int pending_pixels
);
	import rct_pkg::*;

	logic [31:0] tex_mem [0:MEM_DEPTH-1];
	logic [9:0] col_x;
	logic [5:0] tex_col;
	logic [23:0] step_q;
	logic [31:0] accum;
	logic [2:0] tex_sel;
	out_item_t pixel_queue [$];

	initial fail_count = 0;
	assign pending_pixels = pixel_queue.size();

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic column_setup(input in_item_t it);
		logic signed [63:0] prod;
		logic signed [63:0] hit;
		logic [15:0] frac;
		logic [5:0] c;
		logic [31:0] lh;
		logic [63:0] st;
		logic signed [63:0] base;
		col_x = it.column;
		if (it.hit_side == 1'b0)
			prod = $signed({42'd0, it.perp_dist}) * 64'(it.ray_dir_v);
		else
			prod = $signed({42'd0, it.perp_dist}) * 64'(it.ray_dir_h);
		prod = prod >>> 14;
		hit = prod + $signed({42'd0, it.hit_side ? it.pos_h : it.pos_v});
		frac = hit[15:0];
		c = frac[15:10];
		if ((it.hit_side && it.ray_dir_v > 0) || (!it.hit_side && it.ray_dir_h < 0))
			c = 6'(TEX_SIZE - 1) - c;
		tex_col = c;
		if (it.surface == 3'd1)
			tex_sel = DOOR_SOLID_TEX;
		else if (it.surface == 3'd2)
			tex_sel = DOOR_SEE_TEX;
		else if (!it.hit_side)
			tex_sel = it.ray_dir_h > 0 ? 3'd2 : (it.ray_dir_h < 0 ? 3'd3 : NO_TEX);
		else
			tex_sel = it.ray_dir_v < 0 ? 3'd0 : (it.ray_dir_v > 0 ? 3'd1 : NO_TEX);
		lh = (it.line_height == 0) ? 32'd1 : {16'd0, it.line_height};
		st = (64'(TEX_SIZE) << 16) / lh;
		if (st > 64'hFFFFFF)
			st = 64'hFFFFFF;
		step_q = st[23:0];
		base = $signed({54'd0, it.row}) - SCREEN_H / 2 + $signed({33'd0, lh[31:1]});
		accum = 32'(base * $signed(st));
	endtask

	task automatic predict_item(input in_item_t it);
		out_item_t o;
		logic have;
		logic [5:0] tr;
		case (it.opcode)
			OP_SETUP: column_setup(it);
			OP_LOAD: begin
				if (it.surface < NUM_TEXTURES && it.row < TEX_SIZE && it.column < TEX_SIZE)
					tex_mem[{it.surface, it.row[5:0], it.column[5:0]}] = it.texel_value;
			end
			OP_PIXEL: begin
				have = 1'b0;
				o.color = '0;
				accum = accum + {8'd0, step_q};
				tr = accum[21:16];
				if (tex_sel < NUM_TEXTURES) begin
					o.color = tex_mem[{tex_sel, tr, tex_col}];
					if (tex_sel == DOOR_SEE_TEX && o.color == DOOR_CLEAR)
						o.color = BLACK;
					have = 1'b1;
				end
				if (col_x == SCREEN_W / 2 && it.row == SCREEN_H / 2) begin
					o.color = WHITE;
					have = 1'b1;
				end
				o.screen_x = col_x;
				o.screen_y = it.row;
				if (have)
					pixel_queue.push_back(o);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t w;
		if (!arst_n) begin
			col_x = '0;
			tex_col = '0;
			step_q = '0;
			accum = '0;
			tex_sel = NO_TEX;
		end else begin
			if (out_valid && !out_stall) begin
				if (pixel_queue.size() == 0) begin
					report_mismatch("unexpected transfer", out_item.color, 32'd0);
				end else begin
					w = pixel_queue.pop_front();
					if (out_item.screen_x !== w.screen_x)
						report_mismatch("screen_x", 32'(out_item.screen_x), 32'(w.screen_x));
					if (out_item.screen_y !== w.screen_y)
						report_mismatch("screen_y", 32'(out_item.screen_y), 32'(w.screen_y));
					if (out_item.color !== w.color)
						report_mismatch("color", out_item.color, w.color);
				end
			end
			if (in_valid && !in_stall)
				predict_item(in_item);
		end
	end
endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
module tb;
	import rct_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	int fail_count;
	int pending_pixels;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;
	logic [5:0] load_col;

	localparam int WATCHDOG_LIMIT = 20000;

	raycast_wall_column_texturer_top dut (.*);

	rct_scoreboard checker_i (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("raycast_wall_column_texturer_top test failed");
			$finish;
		end
	end

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic in_item_t random_fields();
		in_item_t it;
		logic [191:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = bits[$bits(in_item_t)-1:0];
		return it;
	endfunction

	// Only one column of each texture is loaded; every setup is aimed at it.
	task automatic load_texture(input logic [2:0] t);
		in_item_t it;
		for (int r = 0; r < TEX_SIZE; r++) begin
			it = random_fields();
			it.opcode = OP_LOAD;
			it.surface = t;
			it.row = 10'(r);
			it.column = {4'd0, load_col};
			if (t == DOOR_SEE_TEX && $urandom_range(3) == 0)
				it.texel_value = DOOR_CLEAR;
			send_item(it);
		end
	endtask

	function automatic in_item_t aim_column(input in_item_t it);
		logic signed [63:0] prod;
		logic [15:0] want;
		logic [5:0] c;
		c = load_col;
		if ((it.hit_side && it.ray_dir_v > 0) || (!it.hit_side && it.ray_dir_h < 0))
			c = 6'(TEX_SIZE - 1) - c;
		if (it.hit_side)
			prod = $signed({42'd0, it.perp_dist}) * 64'(it.ray_dir_h);
		else
			prod = $signed({42'd0, it.perp_dist}) * 64'(it.ray_dir_v);
		prod = prod >>> 14;
		want = {c, 10'($urandom)} - prod[15:0];
		if (it.hit_side)
			it.pos_h[15:0] = want;
		else
			it.pos_v[15:0] = want;
		return it;
	endfunction

	task automatic setup_item(input in_item_t it);
		it.opcode = OP_SETUP;
		it = aim_column(it);
		send_item(it);
	endtask

	task automatic pixel_item(input logic [9:0] y);
		in_item_t it;
		it = random_fields();
		it.opcode = OP_PIXEL;
		it.row = y;
		send_item(it);
	endtask

	function automatic in_item_t random_setup();
		in_item_t it;
		it = random_fields();
		it.opcode = OP_SETUP;
		case ($urandom_range(3))
			0: it.line_height = 16'($urandom_range(1, 8));
			1: it.line_height = 16'($urandom_range(1, 1500));
			default: ;
		endcase
		if ($urandom_range(7) == 0) it.ray_dir_h = '0;
		if ($urandom_range(7) == 0) it.ray_dir_v = '0;
		if ($urandom_range(5) == 0) it.column = 10'(SCREEN_W / 2);
		if ($urandom_range(1)) it.surface = 3'($urandom_range(2));
		return it;
	endfunction

	task automatic random_column(input int n);
		in_item_t it;
		it = random_setup();
		setup_item(it);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0) begin
				it = random_fields();
				if (it.opcode == OP_LOAD && it.surface < NUM_TEXTURES)
					it.surface = 3'd7;
				if (it.opcode == OP_SETUP || it.opcode == OP_PIXEL)
					it.opcode = 2'd3;
				send_item(it);
			end else begin
				pixel_item($urandom_range(5) == 0 ? 10'(SCREEN_H / 2) : 10'($urandom));
			end
		end
	endtask

	task automatic random_phase(input int items, input int ip, input int sp);
		int sent;
		int n;
		idle_pct = ip;
		stall_pct = sp;
		sent = 0;
		while (sent < items) begin
			n = $urandom_range(4, 30);
			random_column(n);
			sent += n + 1;
		end
	endtask

	initial begin
		in_item_t it;
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		load_col = 6'($urandom_range(TEX_SIZE - 1));
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pixel_item(10'(SCREEN_H / 2));
		pixel_item(10'd0);
		it = '0;
		it.column = 10'(SCREEN_W / 2);
		it.hit_side = 1'b0;
		setup_item(it);
		pixel_item(10'(SCREEN_H / 2));
		for (int t = 0; t < NUM_TEXTURES; t++)
			load_texture(3'(t));
		it = '1;
		it.opcode = OP_LOAD;
		send_item(it);
		it.surface = 3'd6;
		it.row = 10'd0;
		it.column = 10'd0;
		send_item(it);
		it.opcode = 2'd3;
		send_item(it);

		it = '1;
		it.line_height = 16'hFFFF;
		it.hit_side = 1'b1;
		setup_item(it);
		pixel_item(10'h3FF);
		it = '0;
		it.line_height = 16'd0;
		it.ray_dir_h = 16'sh7FFF;
		it.perp_dist = 22'h3FFFFF;
		setup_item(it);
		pixel_item(10'd0);
		pixel_item(10'd1);
		it.ray_dir_h = 16'sh8000;
		it.pos_v = 22'h3FFFFF;
		it.ray_dir_v = 16'sh8000;
		setup_item(it);
		pixel_item(10'd5);
		it.hit_side = 1'b1;
		it.ray_dir_v = 16'sh7FFF;
		it.surface = 3'd2;
		it.line_height = 16'd1;
		setup_item(it);
		pixel_item(10'd7);
		pixel_item(10'd8);
		it.surface = 3'd1;
		it.ray_dir_v = 16'sh0000;
		setup_item(it);
		pixel_item(10'd9);
		it.surface = 3'd0;
		setup_item(it);
		pixel_item(10'd9);

		random_phase(150, 0, 0);
		in_valid <= 1'b0;
		wait (pending_pixels == 0);
		repeat (50) @(negedge clk);
		random_phase(150, 58, 0);
		random_phase(150, 0, 58);
		random_phase(150, 10, 10);
		random_phase(100, 0, 0);
		in_valid <= 1'b0;

		@(negedge clk);
		idle_pct = 0;
		stall_pct = 0;
		wait (pending_pixels == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("raycast_wall_column_texturer_top test passed");
		else
			$display("raycast_wall_column_texturer_top test failed");
		$finish;
	end
endmodule

/* files.f */
+incdir+src
src/rct_pkg.sv
src/rct_datapath.sv
src/rct_ctrl.sv
src/raycast_wall_column_texturer_top.sv
src/rct_checker.sv
sim/rct_checker.sv
sim/tb.sv
